// File: sv/eav_pkg.sv
`timescale 1ns / 1ps

package eav_pkg;

  // Default number of fraction bits in angle and velocity
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Field and register widths
  localparam int unsigned CPR_W   = 31;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned IN_W    = COUNT_W + TIME_W;
  localparam int unsigned OUT_W   = 3 * COUNT_W;

  // Register reset values
  localparam logic [CPR_W-1:0] CPR_RESET = 31'd4096;

  // 2*pi in Q4.28, and microseconds per second
  localparam logic [31:0] TWO_PI_Q28   = 32'd1686629713;
  localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

  // Shared divider: operand width and step counter width
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // Velocity numerator width: 64-bit quotient times 1e6 plus dt/2 fits in 85 bits
  localparam int unsigned NUM_W = 96;

  // Configuration register index
  typedef enum logic {
    REG_CPR    = 1'b0,
    REG_INVERT = 1'b1
  } cfg_reg_t;

  // Multiplier operand select
  typedef enum logic [2:0] {
    MUL_ANGLE = 3'b001,
    MUL_VLO   = 3'b010,
    MUL_VHI   = 3'b100
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     rezero;
    logic     prep;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div1_start;
    logic     dmag_take;
    logic     acc_upd;
    logic     vel_zero;
    logic     n_add_lo;
    logic     n_add_hi;
    logic     vel_sat;
    logic     div2_start;
    logic     vel_take;
    logic     out_load;
  } eav_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic primed;
    logic dt_zero;
    logic vsat;
    logic div_done;
  } eav_stat_t;

endpackage

// File: sv/eav_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Quotient bits shift into the
// low end of the dividend register as dividend bits leave the top.
module eav_div import eav_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_CNT_W-1:0] steps,
  input  logic [DIV_W-1:0]     rem_init,
  input  logic [DIV_W-1:0]     dvd_init,
  input  logic [DIV_W-1:0]     dsr,
  output logic                 done,
  output logic [DIV_W-1:0]     quot
);

  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     dvd_r;
  logic [DIV_W-1:0]     dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_W:0] shifted;
  logic [DIV_W:0] diff;
  logic           qbit;

  // One trial subtract per cycle
  assign shifted = {rem_r, dvd_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign qbit    = (shifted >= {1'b0, dsr_r});

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dvd_r <= dvd_init;
      dsr_r <= dsr;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      dvd_r <= {dvd_r[DIV_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

// File: sv/eav_dp.sv
`timescale 1ns / 1ps

module eav_dp import eav_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [CPR_W-1:0]   cfg_wdata,
  input  logic [IN_W-1:0]    in_data,
  input  eav_cmd_t           cmd,
  output eav_stat_t          stat,
  output logic [OUT_W-1:0]   out_data
);

  localparam int unsigned DEN_SH = 28 - FRAC_BITS;
  localparam logic signed [65:0] POS_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] POS_MIN = -66'sh0_8000_0000;

  // Config registers
  logic [CPR_W-1:0]   cpr_r;
  logic               invert_r;

  // Tracking state
  logic [COUNT_W-1:0] prev_count_r;
  logic [TIME_W-1:0]  prev_time_r;
  logic [31:0]        acc_r;
  logic               primed_r;

  // Per-item working registers
  logic [COUNT_W-1:0] cnt_r;
  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  dt_r;
  logic [31:0]        mag_r;
  logic               neg_r;
  logic [63:0]        prod_r;
  logic [DIV_W-1:0]   dmag_r;
  logic [NUM_W-1:0]   n_r;
  logic [31:0]        vel_r;

  // Output register payload
  logic [COUNT_W-1:0] out_cnt_r;
  logic [31:0]        out_pos_r;
  logic [31:0]        out_vel_r;

  logic [COUNT_W-1:0] raw;
  logic [COUNT_W-1:0] dc;
  logic [CPR_W-1:0]   cpr_eff;
  logic [63:0]        den;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic signed [65:0] delta;
  logic signed [65:0] sum;
  logic [31:0]        acc_nxt;
  logic               div_start;
  logic [DIV_CNT_W-1:0] div_steps;
  logic [DIV_W-1:0]   div_rem;
  logic [DIV_W-1:0]   div_dvd;
  logic [DIV_W-1:0]   div_dsr;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;

  // Cap the magnitude at 2^31, apply sign, clamp positive side
  function automatic logic [31:0] vel_of(input logic [31:0] q, input logic neg);
    logic [31:0] m;
    m = (q > 32'h8000_0000) ? 32'h8000_0000 : q;
    if (neg) vel_of = 32'd0 - m;
    else if (m[31]) vel_of = 32'h7FFF_FFFF;
    else vel_of = m;
  endfunction

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r    <= CPR_RESET;
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_CPR:    cpr_r    <= cfg_wdata;
        REG_INVERT: invert_r <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // Raw count and count delta
  assign raw = in_data[COUNT_W-1:0];
  assign dc  = cnt_r - prev_count_r;

  // Angle denominator: counts per rev scaled to the output fraction
  assign cpr_eff = (cpr_r == '0) ? CPR_W'(1) : cpr_r;
  assign den     = {33'd0, cpr_eff} << DEN_SH;

  // Shared 32x32 multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_ANGLE: mul_a = mag_r;
      MUL_VLO:   mul_a = dmag_r[31:0];
      MUL_VHI:   mul_a = dmag_r[63:32];
      default:   mul_a = '0;
    endcase
    mul_b = (cmd.mul_sel == MUL_ANGLE) ? TWO_PI_Q28 : USEC_PER_SEC;
  end
  assign mul_p = mul_a * mul_b;

  // Saturating position sum
  always_comb begin
    delta = neg_r ? -$signed({2'b00, dmag_r}) : $signed({2'b00, dmag_r});
    sum   = $signed({{34{acc_r[31]}}, acc_r}) + delta;
    if (sum > POS_MAX) acc_nxt = 32'h7FFF_FFFF;
    else if (sum < POS_MIN) acc_nxt = 32'h8000_0000;
    else acc_nxt = sum[31:0];
  end

  // Divider operands: angle division, then velocity division
  assign div_start = cmd.div1_start | cmd.div2_start;
  always_comb begin
    if (cmd.div2_start) begin
      div_steps = DIV_CNT_W'(DIV_W / 2);
      div_rem   = n_r[NUM_W-1:NUM_W-DIV_W];
      div_dvd   = {n_r[NUM_W-DIV_W-1:0], 32'd0};
      div_dsr   = dt_r;
    end else begin
      div_steps = DIV_CNT_W'(DIV_W);
      div_rem   = '0;
      div_dvd   = prod_r + (den >> 1);
      div_dsr   = den;
    end
  end

  eav_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .steps    (div_steps),
    .rem_init (div_rem),
    .dvd_init (div_dvd),
    .dsr      (div_dsr),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Tracking state: baseline, position, primed flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_count_r <= '0;
      prev_time_r  <= '0;
      acc_r        <= '0;
      primed_r     <= 1'b0;
    end else begin
      if (cmd.rezero) begin
        acc_r    <= '0;
        primed_r <= 1'b0;
      end else if (cmd.prep) begin
        prev_count_r <= cnt_r;
        prev_time_r  <= now_r;
        primed_r     <= 1'b1;
        if (!primed_r) acc_r <= '0;
      end else if (cmd.acc_upd) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt_r <= invert_r ? (COUNT_W'(0) - raw) : raw;
      now_r <= in_data[IN_W-1:COUNT_W];
    end
    if (cmd.prep) begin
      dt_r  <= now_r - prev_time_r;
      neg_r <= dc[COUNT_W-1];
      mag_r <= dc[COUNT_W-1] ? (32'd0 - dc) : dc;
    end
    if (cmd.mul_en) prod_r <= mul_p;
    if (cmd.dmag_take) dmag_r <= div_quot;
    if (cmd.acc_upd) n_r <= {33'd0, dt_r[TIME_W-1:1]};
    else if (cmd.n_add_lo) n_r <= n_r + {32'd0, prod_r};
    else if (cmd.n_add_hi) n_r <= n_r + {prod_r, 32'd0};
    if ((cmd.prep && !primed_r) || cmd.vel_zero) vel_r <= '0;
    else if (cmd.vel_sat) vel_r <= vel_of(32'h8000_0000, neg_r);
    else if (cmd.vel_take) vel_r <= vel_of(div_quot[31:0], neg_r);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cnt_r <= cnt_r;
      out_pos_r <= acc_r;
      out_vel_r <= vel_r;
    end
  end

  assign out_data = {out_vel_r, out_pos_r, out_cnt_r};

  assign stat.primed   = primed_r;
  assign stat.dt_zero  = (dt_r == '0);
  assign stat.vsat     = (n_r[NUM_W-1:NUM_W-DIV_W] >= dt_r);
  assign stat.div_done = div_done;

endmodule

// File: sv/eav_ctrl.sv
`timescale 1ns / 1ps

module eav_ctrl import eav_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_kind,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  eav_stat_t stat,
  output eav_cmd_t  cmd
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_PREP   = 11'b000_0000_0010,
    ST_MUL1   = 11'b000_0000_0100,
    ST_DIVLD1 = 11'b000_0000_1000,
    ST_DIV1   = 11'b000_0001_0000,
    ST_ACC    = 11'b000_0010_0000,
    ST_MULHI  = 11'b000_0100_0000,
    ST_SUMHI  = 11'b000_1000_0000,
    ST_CHK    = 11'b001_0000_0000,
    ST_DIV2   = 11'b010_0000_0000,
    ST_OUT    = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MUL_ANGLE;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          cmd.rezero  = in_kind;
          state_nxt   = in_kind ? ST_IDLE : ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = stat.primed ? ST_MUL1 : ST_OUT;
      end
      ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ANGLE;
        state_nxt   = ST_DIVLD1;
      end
      ST_DIVLD1: begin
        cmd.div1_start = 1'b1;
        state_nxt      = ST_DIV1;
      end
      ST_DIV1: begin
        if (stat.div_done) begin
          cmd.dmag_take = 1'b1;
          state_nxt     = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_upd = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VLO;
        if (stat.dt_zero) begin
          cmd.vel_zero = 1'b1;
          state_nxt    = ST_OUT;
        end else begin
          state_nxt = ST_MULHI;
        end
      end
      ST_MULHI: begin
        cmd.n_add_lo = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_VHI;
        state_nxt    = ST_SUMHI;
      end
      ST_SUMHI: begin
        cmd.n_add_hi = 1'b1;
        state_nxt    = ST_CHK;
      end
      ST_CHK: begin
        if (stat.vsat) begin
          cmd.vel_sat = 1'b1;
          state_nxt   = ST_OUT;
        end else begin
          cmd.div2_start = 1'b1;
          state_nxt      = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (stat.div_done) begin
          cmd.vel_take = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

endmodule

// File: sv/encoder_angle_velocity.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake          | Payload
// in_      | in  | in_tvalid/tready   | tdata: raw_count, time_us; tuser: kind
// out_     | out | out_tvalid/tready  | tdata: count, position, velocity
// cfg_     | in  | cfg_we             | cfg_addr: register index, cfg_wdata
//
// Once primed, a count sample passes these steps before the next is accepted:
// capture, prep, angle multiply, a 64-step divide, forming the velocity
// numerator, a range check and a 32-step divide on the one shared divider.
// A zero time step or a saturated velocity skips the second divide.
// The first sample after reset or rezero sets only the baseline; rezero has no output.
// Reset is synchronous, active low, and clears the position and primed flag.
// The next item is taken while a result still waits in the output register.
module encoder_angle_velocity import eav_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,    // raw_count[31:0], time_us[95:32]
  input  logic              in_tuser,    // kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,   // count[31:0], position[63:32], velocity[95:64]
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [CPR_W-1:0]  cfg_wdata
);

  eav_cmd_t  cmd;
  eav_stat_t stat;

  eav_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  eav_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_tdata)
  );

endmodule
